### rtl/assert_macros.svh
// Assertion macros used by the checker of this block.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_SYNC(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked at every rising edge, during reset too.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/gpr_pkg.sv
// Shared constants and types of the Gaussian pyramid reduce block.
// No dependencies; imported by the top level and by its checker.
`timescale 1ns / 1ps
`default_nettype none

package gpr_pkg;

    localparam int unsigned CFG_W      = 11;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CCOUNT_W   = 3;
    localparam int unsigned NCOMP      = 4;
    localparam int unsigned OUT_POS_W  = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH     = 2'd0,
        REG_IMAGE_HEIGHT    = 2'd1,
        REG_COMPONENT_COUNT = 2'd2
    } t_cfg_reg;

    localparam logic [CFG_W-1:0]    IMAGE_WIDTH_RST     = 11'd640;
    localparam logic [CFG_W-1:0]    IMAGE_HEIGHT_RST    = 11'd480;
    localparam logic [CCOUNT_W-1:0] COMPONENT_COUNT_RST = 3'd4;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int DEF_COMPONENTS  = 4;
    localparam int DEF_SAMPLE_BITS = 16;

    // Ceiling of 2^30 / 5; exact floor division by 5 for operands below 2^30.
    localparam int unsigned  RECIP5_W     = 28;
    localparam int unsigned  RECIP5_SHIFT = 30;
    localparam logic [27:0]  RECIP5       = 28'd214748365;

endpackage

`default_nettype wire

### rtl/gauss_pyramid_reduce_unit.sv
// Gaussian pyramid reduce: 5-tap (1,5,8,5,1)/20 filter across and down, keeping
// every second column and row. Depends on gpr_pkg.
// Input channel: i_in_valid / o_in_stall carry one pixel request of four
// components; configuration goes through i_cfg_we / i_cfg_index / i_cfg_data.
// Output channel: o_out_valid / i_out_stall carry one filtered pixel request
// with its position in the halved frame, a last-of-run flag and a frame-end flag.
// A result passes from its input through stage A, stage B and the output register.
// Throughput: one input per cycle while each input causes at most one result and
// the receiver does not stall; an input causing more than one result holds the input
// side until the single output register has drained its batch of up to four results.
// Row history lives in four banks of MAX_WIDTH/2 entries, read when an input is
// taken and written as that input leaves the first stage.
// Reset clears the counters, the pixel window, the pipeline valids and the
// registers to their defaults; row history needs no clearing.
// When the receiver stalls, the shown result holds and the pipeline backs up
// into o_in_stall once stage B holds a batch and stage A holds an input.
`timescale 1ns / 1ps
`default_nettype none

module gauss_pyramid_reduce_unit #(
    parameter int MAX_WIDTH   = gpr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = gpr_pkg::DEF_MAX_HEIGHT,
    parameter int COMPONENTS  = gpr_pkg::DEF_COMPONENTS,
    parameter int SAMPLE_BITS = gpr_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [gpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gpr_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [SAMPLE_BITS-1:0]         i_sample_c0,
    input  wire logic [SAMPLE_BITS-1:0]         i_sample_c1,
    input  wire logic [SAMPLE_BITS-1:0]         i_sample_c2,
    input  wire logic [SAMPLE_BITS-1:0]         i_sample_c3,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [SAMPLE_BITS-1:0]              o_out_c0,
    output logic [SAMPLE_BITS-1:0]              o_out_c1,
    output logic [SAMPLE_BITS-1:0]              o_out_c2,
    output logic [SAMPLE_BITS-1:0]              o_out_c3,
    output logic [gpr_pkg::OUT_POS_W-1:0]       o_out_column,
    output logic [gpr_pkg::OUT_POS_W-1:0]       o_out_row,
    output logic                                o_last_of_run,
    output logic                                o_frame_end
);
    import gpr_pkg::*;

    localparam int SB      = SAMPLE_BITS;
    localparam int SUMW    = SB + 5;
    localparam int PW      = SUMW - 1 + RECIP5_W;
    localparam int DW      = $clog2(MAX_WIDTH + 1);
    localparam int HDW     = $clog2(MAX_HEIGHT + 1);
    localparam int EW      = (DW > CFG_W) ? DW : CFG_W;
    localparam int EHW     = (HDW > CFG_W) ? HDW : CFG_W;
    localparam int HALF    = MAX_WIDTH / 2;
    localparam int AW      = $clog2(HALF);
    localparam int YW      = $clog2(MAX_HEIGHT / 2);
    localparam int MAXW_E  = MAX_WIDTH - (MAX_WIDTH % 2);
    localparam int MAXH_E  = MAX_HEIGHT - (MAX_HEIGHT % 2);
    localparam int PIXW    = NCOMP * SB;
    localparam logic [SB-1:0] SAMPLE_MAX = {SB{1'b1}};

    typedef struct packed {
        logic          has_h;
        logic          edge_col;
        logic          do_v;
        logic          last_row;
        logic          y0_zero;
        logic [1:0]    rb;
        logic [AW-1:0] x0;
        logic [AW-1:0] x1;
        logic [YW-1:0] y0;
        logic [YW-1:0] y1;
    } t_a_ctl;

    // 1*a + 5*b + 8*c + 5*d + 1*e
    function automatic logic [SUMW-1:0] f_tap5(input logic [SB-1:0] a, input logic [SB-1:0] b,
                                               input logic [SB-1:0] c, input logic [SB-1:0] d,
                                               input logic [SB-1:0] e);
        logic [SUMW-1:0] xa, xb, xc, xd, xe;
        xa = SUMW'(a);
        xb = SUMW'(b);
        xc = SUMW'(c);
        xd = SUMW'(d);
        xe = SUMW'(e);
        return xa + (xb << 2) + xb + (xc << 3) + (xd << 2) + xd + xe;
    endfunction

    // Leading border: 14*a + 5*b + c.
    function automatic logic [SUMW-1:0] f_lead(input logic [SB-1:0] a, input logic [SB-1:0] b,
                                               input logic [SB-1:0] c);
        logic [SUMW-1:0] xa, xb, xc;
        xa = SUMW'(a);
        xb = SUMW'(b);
        xc = SUMW'(c);
        return (xa << 4) - (xa << 1) + (xb << 2) + xb + xc;
    endfunction

    // Trailing border: a + 5*b + 14*c.
    function automatic logic [SUMW-1:0] f_trail(input logic [SB-1:0] a, input logic [SB-1:0] b,
                                                input logic [SB-1:0] c);
        logic [SUMW-1:0] xa, xb, xc;
        xa = SUMW'(a);
        xb = SUMW'(b);
        xc = SUMW'(c);
        return xa + (xb << 2) + xb + (xc << 4) - (xc << 1);
    endfunction

    // Round half up of sum / 20, then saturate: ((sum + 10) >> 2) / 5 by reciprocal.
    function automatic logic [SB-1:0] f_div20(input logic [SUMW-1:0] s);
        logic [SUMW:0]   s10;
        logic [PW-1:0]   p;
        logic [SB+1:0]   q;
        s10 = {1'b0, s} + (SUMW+1)'(10);
        p   = PW'(s10[SUMW:2]) * PW'(RECIP5);
        q   = p[PW-1:RECIP5_SHIFT];
        return (q > (SB+2)'(SAMPLE_MAX)) ? SAMPLE_MAX : q[SB-1:0];
    endfunction

    // Configuration
    logic [CFG_W-1:0]    r_cfg_w;
    logic [CFG_W-1:0]    r_cfg_h;
    logic [CCOUNT_W-1:0] r_cfg_nc;

    logic [EW-1:0]       w_raw;
    logic [EHW-1:0]      h_raw;
    logic [DW-1:0]       w_eff;
    logic [HDW-1:0]      h_eff;
    logic [CCOUNT_W-1:0] nc_eff;
    logic [NCOMP-1:0]    lane_en;

    // Frame position and pixel window
    logic [DW-1:0]  r_col;
    logic [HDW-1:0] r_row;
    logic [DW-1:0]  n_col;
    logic [HDW-1:0] n_row;
    logic [SB-1:0]  r_win [4][NCOMP];
    logic [SB-1:0]  cur   [NCOMP];
    logic [SB-1:0]  smp   [NCOMP];

    // Row history: one bank per row modulo four, plus the last column of each row.
    logic [PIXW-1:0] r_store [4][HALF];
    logic [PIXW-1:0] r_edge  [4];

    // Stage A
    logic            r_a_valid;
    t_a_ctl          r_a;
    t_a_ctl          n_a;
    logic [SUMW-1:0] r_a_hs0  [NCOMP];
    logic [SUMW-1:0] r_a_hs1  [NCOMP];
    logic [SUMW-1:0] n_hs0    [NCOMP];
    logic [SUMW-1:0] n_hs1    [NCOMP];
    logic [PIXW-1:0] r_a_mem  [4];
    logic [PIXW-1:0] r_a_edge [4];

    // Stage B: batch of up to four results
    logic            r_b_valid;
    logic [SUMW-1:0] r_b_sum [4][NCOMP];
    logic [SUMW-1:0] n_b_sum [4][NCOMP];
    logic [AW-1:0]   r_b_x   [4];
    logic [AW-1:0]   n_b_x   [4];
    logic [YW-1:0]   r_b_y   [4];
    logic [YW-1:0]   n_b_y   [4];
    logic [1:0]      r_b_last;
    logic [1:0]      n_b_last;
    logic            n_b_any;
    logic [1:0]      r_b_ptr;
    logic [PIXW-1:0] hval0;
    logic [PIXW-1:0] hval1;

    // Output register
    logic            r_o_valid;
    logic [SB-1:0]   r_o_c [NCOMP];
    logic [AW-1:0]   r_o_x;
    logic [YW-1:0]   r_o_y;
    logic            r_o_last;
    logic            r_o_fe;

    // Handshake
    logic in_acc;
    logic a_free;
    logic b_adv;
    logic b_done;
    logic out_load;

    assign w_raw = EW'({r_cfg_w[CFG_W-1:1], 1'b0});
    assign h_raw = EHW'({r_cfg_h[CFG_W-1:1], 1'b0});

    always_comb begin
        if (w_raw > EW'(MAXW_E)) begin
            w_eff = DW'(MAXW_E);
        end else if (w_raw < EW'(4)) begin
            w_eff = DW'(4);
        end else begin
            w_eff = DW'(w_raw);
        end
        if (h_raw > EHW'(MAXH_E)) begin
            h_eff = HDW'(MAXH_E);
        end else if (h_raw < EHW'(4)) begin
            h_eff = HDW'(4);
        end else begin
            h_eff = HDW'(h_raw);
        end
        if (r_cfg_nc == '0) begin
            nc_eff = CCOUNT_W'(1);
        end else if (r_cfg_nc > CCOUNT_W'(COMPONENTS)) begin
            nc_eff = CCOUNT_W'(COMPONENTS);
        end else begin
            nc_eff = r_cfg_nc;
        end
        for (int k = 0; k < NCOMP; k++) begin
            lane_en[k] = CCOUNT_W'(k) < nc_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= IMAGE_WIDTH_RST;
            r_cfg_h  <= IMAGE_HEIGHT_RST;
            r_cfg_nc <= COMPONENT_COUNT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH: begin
                    r_cfg_w <= i_cfg_data;
                end
                REG_IMAGE_HEIGHT: begin
                    r_cfg_h <= i_cfg_data;
                end
                REG_COMPONENT_COUNT: begin
                    r_cfg_nc <= i_cfg_data[CCOUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake: the output register drains the batch in stage B one result a cycle while the receiver does not stall.
    assign out_load   = r_b_valid && (!r_o_valid || !i_out_stall);
    assign b_done     = out_load && (r_b_ptr == r_b_last);
    assign b_adv      = r_a_valid && (!r_b_valid || b_done);
    assign a_free     = !r_a_valid || b_adv;
    assign o_in_stall = !a_free;
    assign in_acc     = i_in_valid && a_free;

    // Input side: position decode and horizontal sums.
    assign smp[0] = i_sample_c0;
    assign smp[1] = i_sample_c1;
    assign smp[2] = i_sample_c2;
    assign smp[3] = i_sample_c3;

    always_comb begin
        logic [DW:0]  c1;
        logic [DW:0]  c2;
        logic [HDW:0] r1;
        logic [HDW:0] r2;
        logic         x0_zero;
        c1 = {1'b0, r_col} + (DW+1)'(1);
        c2 = {1'b0, r_col} + (DW+1)'(2);
        r1 = {1'b0, r_row} + (HDW+1)'(1);
        r2 = {1'b0, r_row} + (HDW+1)'(2);

        n_a.has_h    = !r_col[0] && (r_col != '0) && (c2 <= {1'b0, w_eff});
        n_a.edge_col = n_a.has_h && (c2 == {1'b0, w_eff});
        n_a.do_v     = !r_row[0] && (r_row != '0) && (r2 <= {1'b0, h_eff});
        n_a.last_row = n_a.do_v && (r2 == {1'b0, h_eff});
        n_a.y0_zero  = r_row[HDW-1:1] == (HDW-1)'(1);
        n_a.rb       = r_row[1:0];
        n_a.x0       = AW'(r_col[DW-1:1] - (DW-1)'(1));
        n_a.x1       = AW'(w_eff[DW-1:1] - (DW-1)'(1));
        n_a.y0       = YW'(r_row[HDW-1:1] - (HDW-1)'(1));
        n_a.y1       = YW'(h_eff[HDW-1:1] - (HDW-1)'(1));
        x0_zero      = r_col[DW-1:1] == (DW-1)'(1);

        for (int k = 0; k < NCOMP; k++) begin
            cur[k] = lane_en[k] ? smp[k] : '0;
            if (x0_zero) begin
                n_hs0[k] = f_lead(r_win[1][k], r_win[0][k], cur[k]);
            end else begin
                n_hs0[k] = f_tap5(r_win[3][k], r_win[2][k], r_win[1][k], r_win[0][k], cur[k]);
            end
            n_hs1[k] = f_trail(r_win[1][k], r_win[0][k], cur[k]);
        end

        n_col = r_col;
        n_row = r_row;
        if (c1 >= {1'b0, w_eff}) begin
            n_col = '0;
            n_row = (r1 >= {1'b0, h_eff}) ? '0 : r1[HDW-1:0];
        end else begin
            n_col = c1[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
            for (int j = 0; j < 4; j++) begin
                for (int k = 0; k < NCOMP; k++) begin
                    r_win[j][k] <= '0;
                end
            end
        end else begin
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
                for (int k = 0; k < NCOMP; k++) begin
                    r_win[3][k] <= r_win[2][k];
                    r_win[2][k] <= r_win[1][k];
                    r_win[1][k] <= r_win[0][k];
                    r_win[0][k] <= cur[k];
                end
            end
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (b_adv) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // Stage A payload, with the row history read for this column.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a <= n_a;
            for (int k = 0; k < NCOMP; k++) begin
                r_a_hs0[k] <= n_hs0[k];
                r_a_hs1[k] <= n_hs1[k];
            end
            for (int b = 0; b < 4; b++) begin
                r_a_mem[b]  <= r_store[b][n_a.x0];
                r_a_edge[b] <= r_edge[b];
            end
        end
    end

    // The horizontal results go into history as the item leaves stage A.
    always_ff @(posedge i_clk) begin
        if (b_adv && r_a.has_h) begin
            r_store[r_a.rb][r_a.x0] <= hval0;
        end
        if (b_adv && r_a.edge_col) begin
            r_edge[r_a.rb] <= hval1;
        end
    end

    // Vertical sums for the four possible results, in raster order of the output.
    always_comb begin
        logic [1:0]    b1, b2, b3;
        logic [SB-1:0] v0, v1;
        logic [SUMW-1:0] t0, t1, l0, l1;
        b1 = r_a.rb - 2'd1;
        b2 = r_a.rb - 2'd2;
        b3 = r_a.rb - 2'd3;
        for (int k = 0; k < NCOMP; k++) begin
            hval0[k*SB +: SB] = f_div20(r_a_hs0[k]);
            hval1[k*SB +: SB] = f_div20(r_a_hs1[k]);
        end
        for (int k = 0; k < NCOMP; k++) begin
            v0 = hval0[k*SB +: SB];
            v1 = hval1[k*SB +: SB];
            if (r_a.y0_zero) begin
                t0 = f_lead(r_a_mem[b2][k*SB +: SB], r_a_mem[b1][k*SB +: SB], v0);
                t1 = f_lead(r_a_edge[b2][k*SB +: SB], r_a_edge[b1][k*SB +: SB], v1);
            end else begin
                t0 = f_tap5(r_a_mem[r_a.rb][k*SB +: SB], r_a_mem[b3][k*SB +: SB],
                            r_a_mem[b2][k*SB +: SB], r_a_mem[b1][k*SB +: SB], v0);
                t1 = f_tap5(r_a_edge[r_a.rb][k*SB +: SB], r_a_edge[b3][k*SB +: SB],
                            r_a_edge[b2][k*SB +: SB], r_a_edge[b1][k*SB +: SB], v1);
            end
            l0 = f_trail(r_a_mem[b2][k*SB +: SB], r_a_mem[b1][k*SB +: SB], v0);
            l1 = f_trail(r_a_edge[b2][k*SB +: SB], r_a_edge[b1][k*SB +: SB], v1);
            n_b_sum[0][k] = t0;
            n_b_sum[1][k] = r_a.edge_col ? t1 : l0;
            n_b_sum[2][k] = l0;
            n_b_sum[3][k] = l1;
        end
        n_b_x[0] = r_a.x0;
        n_b_x[1] = r_a.edge_col ? r_a.x1 : r_a.x0;
        n_b_x[2] = r_a.x0;
        n_b_x[3] = r_a.x1;
        n_b_y[0] = r_a.y0;
        n_b_y[1] = r_a.edge_col ? r_a.y0 : r_a.y1;
        n_b_y[2] = r_a.y1;
        n_b_y[3] = r_a.y1;
        n_b_any  = r_a.has_h && r_a.do_v;
        if (r_a.edge_col && r_a.last_row) begin
            n_b_last = 2'd3;
        end else if (r_a.edge_col || r_a.last_row) begin
            n_b_last = 2'd1;
        end else begin
            n_b_last = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_ptr   <= '0;
        end else begin
            if (b_adv) begin
                r_b_valid <= n_b_any;
            end else if (b_done) begin
                r_b_valid <= 1'b0;
            end
            if (b_done) begin
                r_b_ptr <= '0;
            end else if (out_load) begin
                r_b_ptr <= r_b_ptr + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_b_sum  <= n_b_sum;
            r_b_x    <= n_b_x;
            r_b_y    <= n_b_y;
            r_b_last <= n_b_last;
        end
    end

    // Output register. Only the fourth result of a batch can be the last pixel of
    // the frame: it is the only one at the last column and the last row together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int k = 0; k < NCOMP; k++) begin
                r_o_c[k] <= lane_en[k] ? f_div20(r_b_sum[r_b_ptr][k]) : '0;
            end
            r_o_x    <= r_b_x[r_b_ptr];
            r_o_y    <= r_b_y[r_b_ptr];
            r_o_last <= r_b_ptr == r_b_last;
            r_o_fe   <= r_b_ptr == 2'd3;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_out_c0      = r_o_c[0];
    assign o_out_c1      = r_o_c[1];
    assign o_out_c2      = r_o_c[2];
    assign o_out_c3      = r_o_c[3];
    assign o_out_column  = OUT_POS_W'(r_o_x);
    assign o_out_row     = OUT_POS_W'(r_o_y);
    assign o_last_of_run = r_o_last;
    assign o_frame_end   = r_o_fe;

endmodule

`default_nettype wire

### rtl/gpr_checker.sv
// Port-level checker for gauss_pyramid_reduce_unit, bound to the top level.
// Depends on gpr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gpr_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_stall,
    input wire logic                           i_last,
    input wire logic                           i_frame_end,
    input wire logic [gpr_pkg::OUT_POS_W-1:0]  i_col,
    input wire logic [gpr_pkg::OUT_POS_W-1:0]  i_row
);
    import gpr_pkg::*;

    // A stalled result request stays offered.
    `ASSERT_SYNC(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall |=> i_out_valid, "output request dropped while stalled")

    // The final pixel of a frame always closes the run of its input.
    `ASSERT_SYNC(a_fe_last, i_clk, i_rst_n, i_out_valid && i_frame_end |-> i_last, "frame end without last of run")

    // Frames are at least four pixels across and down, so the final pixel is never at zero.
    `ASSERT_SYNC(a_fe_pos, i_clk, i_rst_n, i_out_valid && i_frame_end |-> (i_col != '0) && (i_row != '0), "frame end at column or row zero")

    // Nothing is offered in the cycle after a reset edge.
    `ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !i_out_valid, "output request right after reset")

endmodule

bind gauss_pyramid_reduce_unit gpr_checker u_gpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_last      (o_last_of_run),
    .i_frame_end (o_frame_end),
    .i_col       (o_out_column),
    .i_row       (o_out_row)
);

`default_nettype wire
